// File: hdl/isobpr_pkg.sv
// ----------------------------------------------------------------------------
// isobpr_pkg
// shared types, command codes and CRC_B helpers for the type B card responder
// ----------------------------------------------------------------------------
package isobpr_pkg;

    // input item: leading fields of one received frame
    typedef struct packed {
        logic [7:0]  first_byte;
        logic [31:0] pupi_in;
        logic [7:0]  attrib_param2;
        logic [7:0]  attrib_cid;
    } t_in;

    // result item: one transmitted byte
    typedef struct packed {
        logic [7:0] tx_byte;
        logic       last_byte;
        logic       respond;
    } t_out;

    // command kinds passed from decoder to transmitter
    localparam logic [2:0] CMD_NORESP = 3'd0;
    localparam logic [2:0] CMD_ATQB   = 3'd1;
    localparam logic [2:0] CMD_BYTE   = 3'd2;
    localparam logic [2:0] CMD_EMPTY  = 3'd3;
    localparam logic [2:0] CMD_RESEND = 3'd4;

    typedef struct packed {
        logic [2:0] kind;
        logic [7:0] data;
    } t_cmd;

    // configuration register indexes
    localparam logic CFG_CARD_PUPI   = 1'b0;
    localparam logic CFG_CID_SUPPORT = 1'b1;

    localparam logic [31:0] CARD_PUPI_RST = 32'h2345_4567;

    // command decoding constants
    localparam logic [3:0] REQB_NIBBLE = 4'h5;
    localparam logic [7:0] CMD_ATTRIB  = 8'h1D;
    localparam logic [7:0] CMD_HLTB    = 8'h50;
    localparam logic [7:0] IBLK_MASK   = 8'hE2;
    localparam logic [7:0] IBLK_VAL    = 8'h02;
    localparam logic [7:0] SBLK_MASK   = 8'hC7;
    localparam logic [7:0] SBLK_VAL    = 8'hC2;
    localparam logic [7:0] RBLK_MASK   = 8'hE6;
    localparam logic [7:0] RBLK_VAL    = 8'hA2;
    localparam logic [7:0] RACK_BASE   = 8'hA2;
    localparam logic [7:0] RACK_KEEP   = 8'h09;
    localparam logic [7:0] HLTB_ANSWER = 8'h00;

    // ATQB content
    localparam logic [7:0] ATQB_HEAD   = 8'h50;
    localparam logic [7:0] ATQB_PROT1  = 8'h81;
    localparam logic [7:0] ATQB_PROT2  = 8'h40;
    localparam int         ATQB_LEN    = 12;

    // CRC_B, reflected 0x1021
    localparam logic [15:0] CRC_PRESET = 16'hFFFF;
    localparam logic [15:0] CRC_POLY   = 16'h8408;

    function automatic logic [15:0] crcb_update(input logic [15:0] crc,
                                                input logic [7:0]  b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

    // byte idx of the ATQB frame
    function automatic logic [7:0] atqb_byte(input logic [3:0]  idx,
                                             input logic [31:0] pupi,
                                             input logic        cid);
        logic [7:0] b;
        case (idx)
            4'd0:    b = ATQB_HEAD;
            4'd1:    b = pupi[31:24];
            4'd2:    b = pupi[23:16];
            4'd3:    b = pupi[15:8];
            4'd4:    b = pupi[7:0];
            4'd10:   b = ATQB_PROT1;
            4'd11:   b = ATQB_PROT2 | {7'd0, cid};
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

// File: hdl/isobpr_front.sv
// ----------------------------------------------------------------------------
// isobpr_front
// frame decoder: classifies each item and keeps the block number
// ----------------------------------------------------------------------------
module isobpr_front import isobpr_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_push,
    input  t_in         i_item,
    input  logic [31:0] i_card_pupi,
    input  logic        i_q_full,
    output logic        o_full,
    output logic        o_q_push,
    output t_cmd        o_q_cmd
);

    logic r_block_num;
    logic n_block_num;
    logic [7:0] fb;

    assign fb       = i_item.first_byte;
    assign o_full   = i_q_full;
    assign o_q_push = i_push && !i_q_full;

    always_comb begin
        n_block_num  = r_block_num;
        o_q_cmd.kind = CMD_NORESP;
        o_q_cmd.data = 8'h00;
        if (fb[3:0] == REQB_NIBBLE) begin
            n_block_num  = 1'b1;
            o_q_cmd.kind = CMD_ATQB;
        end else if (fb == CMD_ATTRIB) begin
            if (i_item.pupi_in == i_card_pupi) begin
                o_q_cmd.kind = CMD_BYTE;
                o_q_cmd.data = {i_item.attrib_param2[3:0], i_item.attrib_cid[3:0]};
            end
        end else if ((fb & IBLK_MASK) == IBLK_VAL) begin
            n_block_num  = !r_block_num;
            o_q_cmd.kind = CMD_BYTE;
            // chained block is acknowledged
            o_q_cmd.data = fb[4] ? (RACK_BASE | (fb & RACK_KEEP)) : fb;
        end else if ((fb & SBLK_MASK) == SBLK_VAL) begin
            o_q_cmd.kind = CMD_BYTE;
            o_q_cmd.data = fb;
        end else if ((fb & RBLK_MASK) == RBLK_VAL) begin
            if (fb[0] != r_block_num) begin
                n_block_num  = !r_block_num;
                o_q_cmd.kind = CMD_EMPTY;
            end else begin
                o_q_cmd.kind = CMD_RESEND;
            end
        end else if (fb == CMD_HLTB) begin
            o_q_cmd.kind = CMD_BYTE;
            o_q_cmd.data = HLTB_ANSWER;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_block_num <= 1'b1;
        end else if (o_q_push) begin
            r_block_num <= n_block_num;
        end
    end

endmodule

// File: hdl/isobpr_cmdq.sv
// ----------------------------------------------------------------------------
// isobpr_cmdq
// two-entry command queue between decoder and transmitter
// ----------------------------------------------------------------------------
module isobpr_cmdq import isobpr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output logic o_full,
    output logic o_empty,
    output t_cmd o_cmd
);

    localparam int DEPTH = 2;

    t_cmd       r_slot [DEPTH];
    logic       r_wr_ptr;
    logic       r_rd_ptr;
    logic [1:0] r_count;

    assign o_full  = (r_count == 2'(DEPTH));
    assign o_empty = (r_count == 2'd0);
    assign o_cmd   = r_slot[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (i_push && !o_full) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= 1'b0;
            r_rd_ptr <= 1'b0;
            r_count  <= 2'd0;
        end else begin
            if (i_push && !o_full) begin
                r_wr_ptr <= !r_wr_ptr;
            end
            if (i_pop && !o_empty) begin
                r_rd_ptr <= !r_rd_ptr;
            end
            r_count <= r_count + 2'((i_push && !o_full) ? 1 : 0)
                               - 2'((i_pop && !o_empty) ? 1 : 0);
        end
    end

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= 2'(DEPTH))
        else $error("command queue count overrun");

endmodule

// File: hdl/isobpr_back.sv
// ----------------------------------------------------------------------------
// isobpr_back
// transmitter: emits response bytes with CRC_B or a no-response item, and keeps the last frame
// ----------------------------------------------------------------------------
module isobpr_back import isobpr_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_q_empty,
    input  t_cmd        i_q_cmd,
    output logic        o_q_pop,
    input  logic [31:0] i_card_pupi,
    input  logic        i_cid_support,
    input  logic        i_pop,
    output logic        o_empty,
    output t_out        o_item
);

    localparam int LEN_W  = $clog2(MAX_FRAME_BYTES + 1);
    localparam int ADDR_W = $clog2(MAX_FRAME_BYTES);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_NRSP = 3'd1;
    localparam logic [2:0] ST_DATA = 3'd2;
    localparam logic [2:0] ST_CRCL = 3'd3;
    localparam logic [2:0] ST_CRCH = 3'd4;

    logic [2:0]       r_state, n_state;
    logic [2:0]       r_kind, n_kind;
    logic [7:0]       r_data, n_data;
    logic [LEN_W-1:0] r_len, n_len;
    logic [LEN_W-1:0] r_idx, n_idx;
    logic [LEN_W-1:0] r_last_len, n_last_len;
    logic [15:0]      r_crc, n_crc;
    t_out             r_out, n_out;
    logic             r_out_vld, n_out_vld;

    logic [7:0] r_mem [MAX_FRAME_BYTES];
    logic [7:0] r_rd_data;
    logic [7:0] cur_byte;
    logic       wr_en;
    logic       can_emit;

    assign can_emit = !r_out_vld || i_pop;
    assign o_empty  = !r_out_vld;
    assign o_item   = r_out;

    always_comb begin
        case (r_kind)
            CMD_ATQB:   cur_byte = atqb_byte(r_idx[3:0], i_card_pupi, i_cid_support);
            CMD_BYTE:   cur_byte = r_data;
            CMD_RESEND: cur_byte = r_rd_data;
            default:    cur_byte = 8'h00;
        endcase
    end

    always_comb begin
        n_state    = r_state;
        n_kind     = r_kind;
        n_data     = r_data;
        n_len      = r_len;
        n_idx      = r_idx;
        n_last_len = r_last_len;
        n_crc      = r_crc;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !i_pop;
        o_q_pop    = 1'b0;
        wr_en      = 1'b0;
        case (r_state)
            ST_IDLE: begin
                n_idx = '0;
                if (!i_q_empty) begin
                    o_q_pop = 1'b1;
                    n_kind  = i_q_cmd.kind;
                    n_data  = i_q_cmd.data;
                    n_crc   = CRC_PRESET;
                    case (i_q_cmd.kind)
                        CMD_ATQB: begin
                            n_len      = LEN_W'(ATQB_LEN);
                            n_last_len = LEN_W'(ATQB_LEN);
                            n_state    = ST_DATA;
                        end
                        CMD_BYTE: begin
                            n_len      = LEN_W'(1);
                            n_last_len = LEN_W'(1);
                            n_state    = ST_DATA;
                        end
                        CMD_EMPTY: begin
                            n_len      = '0;
                            n_last_len = '0;
                            n_state    = ST_CRCL;
                        end
                        CMD_RESEND: begin
                            n_len   = r_last_len;
                            n_state = (r_last_len == '0) ? ST_CRCL : ST_DATA;
                        end
                        default: begin
                            n_state = ST_NRSP;
                        end
                    endcase
                end
            end
            ST_NRSP: begin
                if (can_emit) begin
                    n_out_vld = 1'b1;
                    n_out     = '{tx_byte: 8'h00, last_byte: 1'b1, respond: 1'b0};
                    n_state   = ST_IDLE;
                end
            end
            ST_DATA: begin
                if (can_emit) begin
                    n_out_vld = 1'b1;
                    n_out     = '{tx_byte: cur_byte, last_byte: 1'b0, respond: 1'b1};
                    wr_en     = (r_kind != CMD_RESEND);
                    n_crc     = crcb_update(r_crc, cur_byte);
                    n_idx     = r_idx + LEN_W'(1);
                    if (n_idx == r_len) begin
                        n_state = ST_CRCL;
                    end
                end
            end
            ST_CRCL: begin
                if (can_emit) begin
                    n_out_vld = 1'b1;
                    n_out     = '{tx_byte: ~r_crc[7:0], last_byte: 1'b0, respond: 1'b1};
                    n_state   = ST_CRCH;
                end
            end
            ST_CRCH: begin
                if (can_emit) begin
                    n_out_vld = 1'b1;
                    n_out     = '{tx_byte: ~r_crc[15:8], last_byte: 1'b1, respond: 1'b1};
                    n_state   = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // last frame store, read one byte ahead of use
    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[r_idx[ADDR_W-1:0]] <= cur_byte;
        end
        if (n_idx < LEN_W'(MAX_FRAME_BYTES)) begin
            r_rd_data <= r_mem[n_idx[ADDR_W-1:0]];
        end
    end

    always_ff @(posedge i_clk) begin
        r_kind <= n_kind;
        r_data <= n_data;
        r_len  <= n_len;
        r_idx  <= n_idx;
        r_crc  <= n_crc;
        r_out  <= n_out;
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_last_len <= '0;
            r_out_vld  <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_last_len <= n_last_len;
            r_out_vld  <= n_out_vld;
        end
    end

    a_noresp_form: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_vld && !r_out.respond |-> r_out.last_byte && r_out.tx_byte == 8'h00)
        else $error("no-response item malformed");

    a_idx_in_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_DATA |-> r_idx < r_len && r_len <= LEN_W'(MAX_FRAME_BYTES))
        else $error("byte index past frame length");

    a_crc_closes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CRCH && can_emit |=> r_out_vld && r_out.last_byte && r_state == ST_IDLE)
        else $error("frame not closed after CRC high byte");

endmodule

// File: hdl/iso14443b_picc_responder_top.sv
// ----------------------------------------------------------------------------
// iso14443b_picc_responder_top
// type B card block-protocol responder: decoder, command queue, transmitter
// ----------------------------------------------------------------------------
// Each item holds the leading fields of one received frame. The decoder
// classifies it (REQB/WUPB, ATTRIB, I-, S-, R-block, HLTB, unknown) in the
// cycle it is accepted and queues a short command; the transmitter then sends
// the response one byte per cycle while the output register can take a byte,
// followed by the two CRC_B bytes, the last byte flagged. For each frame the
// transmitter first takes the command from the queue in its idle state, then
// sends the data bytes and then the two CRC bytes: the 12-byte ATQB, a one-byte
// answer and an empty frame of CRC only; a frame with no answer gives a single
// no-response item instead. A two-entry command queue lets up to two further
// items be accepted while a frame is still being sent, and an output register
// keeps the input side moving while a result waits. The user must write
// configuration only while the block is idle; the block does not enforce it.
module iso14443b_picc_responder_top import isobpr_pkg::*; #(
    parameter int MAX_FRAME_BYTES = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // input queue side
    input  logic        push,
    output logic        full,
    input  t_in         i_item,
    // result queue side
    output logic        empty,
    input  logic        pop,
    output t_out        o_item,
    // configuration write port
    input  logic        i_cfg_we,
    input  logic        i_cfg_idx,
    input  logic [31:0] i_cfg_wdata
);

    // configuration registers
    logic [31:0] r_card_pupi;
    logic        r_cid_support;

    // decoder to queue
    logic q_push;
    t_cmd q_in_cmd;
    logic q_full;

    // queue to transmitter
    logic q_pop;
    logic q_empty;
    t_cmd q_out_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_card_pupi   <= CARD_PUPI_RST;
            r_cid_support <= 1'b1;
        end else if (i_cfg_we) begin
            case (i_cfg_idx)
                CFG_CARD_PUPI:   r_card_pupi   <= i_cfg_wdata;
                CFG_CID_SUPPORT: r_cid_support <= i_cfg_wdata[0];
                default: ;
            endcase
        end
    end

    // frame decoder, owns the block number
    isobpr_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (i_item),
        .i_card_pupi (r_card_pupi),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_cmd     (q_in_cmd)
    );

    // decouples decoding from transmission
    isobpr_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_cmd   (q_in_cmd),
        .i_pop   (q_pop),
        .o_full  (q_full),
        .o_empty (q_empty),
        .o_cmd   (q_out_cmd)
    );

    // byte transmitter, owns the last frame and its length
    isobpr_back #(
        .MAX_FRAME_BYTES (MAX_FRAME_BYTES)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_empty     (q_empty),
        .i_q_cmd       (q_out_cmd),
        .o_q_pop       (q_pop),
        .i_card_pupi   (r_card_pupi),
        .i_cid_support (r_cid_support),
        .i_pop         (pop),
        .o_empty       (empty),
        .o_item        (o_item)
    );

endmodule
